// ===== rtl/core/qpt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the quad patch tessellator.
// No dependencies; every other file in rtl/core depends on this package.
package qpt_pkg;

	// Grid limits and field widths
	localparam int QPT_MAX_N = 64;   // largest usable subdivision count
	localparam int CELL_W    = 6;
	localparam int CNT_W     = 7;    // holds 0..QPT_MAX_N and the register itself
	localparam int CRD_W     = 16;   // Q4.12 coordinate
	localparam int NRM_W     = 36;   // normal, 24 fraction bits
	localparam int SLOT_W    = 3;
	localparam int CFG_W     = 48;
	localparam int REG_IDX_W = 3;

	// Q1.16 patch parameter, 0..65536
	localparam int Q_FRAC  = 16;
	localparam int PARAM_W = Q_FRAC + 1;

	// Reciprocal table: floor(2^24 / n), estimate is (k * rcp) >> 8
	localparam int RCP_FRAC = 24;
	localparam int RCP_W    = RCP_FRAC + 1;
	localparam int RCP_SH   = RCP_FRAC - Q_FRAC;
	localparam int RCP_ONE  = 1 << RCP_FRAC;

	typedef logic [CELL_W-1:0]           cell_t;
	typedef logic [CNT_W-1:0]            cnt_t;
	typedef logic [PARAM_W-1:0]          param_t;
	typedef logic [RCP_W-1:0]            rcp_t;
	typedef logic [SLOT_W-1:0]           slot_t;
	typedef logic [CFG_W-1:0]            cfg_data_t;
	typedef logic [REG_IDX_W-1:0]        reg_idx_t;
	typedef logic signed [CRD_W-1:0]     coord_t;
	typedef logic signed [CRD_W:0]       diff_t;
	typedef logic signed [CRD_W+2:0]     sum_t;
	typedef logic signed [2*CRD_W+2:0]   prod_t;   // diff x Q1.16 parameter
	typedef logic signed [2*CRD_W+1:0]   xprod_t;  // diff x diff
	typedef logic signed [NRM_W-1:0]     norm_t;

	// Register map
	localparam reg_idx_t REG_CORNER_ZERO  = 3'd0;
	localparam reg_idx_t REG_CORNER_ONE   = 3'd1;
	localparam reg_idx_t REG_CORNER_TWO   = 3'd2;
	localparam reg_idx_t REG_CORNER_THREE = 3'd3;
	localparam reg_idx_t REG_SUBDIVISIONS = 3'd4;

	// x in the top bits, z in the low bits, matching the register packing
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} dvec_t;

	typedef struct packed {
		prod_t x;
		prod_t y;
		prod_t z;
	} pvec_t;

	typedef struct packed {
		norm_t x;
		norm_t y;
		norm_t z;
	} nvec_t;

	// Cross product partial terms: n.x = xa - xb, etc.
	typedef struct packed {
		xprod_t xa;
		xprod_t xb;
		xprod_t ya;
		xprod_t yb;
		xprod_t za;
		xprod_t zb;
	} xpart_t;

	// Patch geometry derived from the corner registers
	typedef struct packed {
		vec_t  c0;
		vec_t  c3;
		dvec_t e01;
		dvec_t e32;
	} patch_t;

	typedef struct packed {
		param_t u0;
		param_t u1;
		param_t v0;
		param_t v1;
	} uv_t;

	typedef struct packed {
		vec_t p0;
		vec_t p1;
		vec_t p2;
		vec_t p3;
	} quad_t;

	typedef struct packed {
		quad_t pos;
		nvec_t n1;
		nvec_t n2;
	} cell_res_t;

	// floor(2^24 / n), entry n-1
	localparam rcp_t RCP_TBL [QPT_MAX_N] = '{
		rcp_t'(RCP_ONE / 1),  rcp_t'(RCP_ONE / 2),  rcp_t'(RCP_ONE / 3),  rcp_t'(RCP_ONE / 4),
		rcp_t'(RCP_ONE / 5),  rcp_t'(RCP_ONE / 6),  rcp_t'(RCP_ONE / 7),  rcp_t'(RCP_ONE / 8),
		rcp_t'(RCP_ONE / 9),  rcp_t'(RCP_ONE / 10), rcp_t'(RCP_ONE / 11), rcp_t'(RCP_ONE / 12),
		rcp_t'(RCP_ONE / 13), rcp_t'(RCP_ONE / 14), rcp_t'(RCP_ONE / 15), rcp_t'(RCP_ONE / 16),
		rcp_t'(RCP_ONE / 17), rcp_t'(RCP_ONE / 18), rcp_t'(RCP_ONE / 19), rcp_t'(RCP_ONE / 20),
		rcp_t'(RCP_ONE / 21), rcp_t'(RCP_ONE / 22), rcp_t'(RCP_ONE / 23), rcp_t'(RCP_ONE / 24),
		rcp_t'(RCP_ONE / 25), rcp_t'(RCP_ONE / 26), rcp_t'(RCP_ONE / 27), rcp_t'(RCP_ONE / 28),
		rcp_t'(RCP_ONE / 29), rcp_t'(RCP_ONE / 30), rcp_t'(RCP_ONE / 31), rcp_t'(RCP_ONE / 32),
		rcp_t'(RCP_ONE / 33), rcp_t'(RCP_ONE / 34), rcp_t'(RCP_ONE / 35), rcp_t'(RCP_ONE / 36),
		rcp_t'(RCP_ONE / 37), rcp_t'(RCP_ONE / 38), rcp_t'(RCP_ONE / 39), rcp_t'(RCP_ONE / 40),
		rcp_t'(RCP_ONE / 41), rcp_t'(RCP_ONE / 42), rcp_t'(RCP_ONE / 43), rcp_t'(RCP_ONE / 44),
		rcp_t'(RCP_ONE / 45), rcp_t'(RCP_ONE / 46), rcp_t'(RCP_ONE / 47), rcp_t'(RCP_ONE / 48),
		rcp_t'(RCP_ONE / 49), rcp_t'(RCP_ONE / 50), rcp_t'(RCP_ONE / 51), rcp_t'(RCP_ONE / 52),
		rcp_t'(RCP_ONE / 53), rcp_t'(RCP_ONE / 54), rcp_t'(RCP_ONE / 55), rcp_t'(RCP_ONE / 56),
		rcp_t'(RCP_ONE / 57), rcp_t'(RCP_ONE / 58), rcp_t'(RCP_ONE / 59), rcp_t'(RCP_ONE / 60),
		rcp_t'(RCP_ONE / 61), rcp_t'(RCP_ONE / 62), rcp_t'(RCP_ONE / 63), rcp_t'(RCP_ONE / 64)
	};

	// Component-wise difference, one bit wider
	function automatic dvec_t vsub(vec_t a, vec_t b);
		dvec_t r;
		r.x = diff_t'(a.x) - diff_t'(b.x);
		r.y = diff_t'(a.y) - diff_t'(b.y);
		r.z = diff_t'(a.z) - diff_t'(b.z);
		return r;
	endfunction

	// Difference scaled by an unsigned Q1.16 parameter
	function automatic pvec_t vmul(dvec_t d, param_t t);
		prod_t ts;
		pvec_t r;
		ts  = prod_t'($signed({1'b0, t}));
		r.x = prod_t'(d.x) * ts;
		r.y = prod_t'(d.y) * ts;
		r.z = prod_t'(d.z) * ts;
		return r;
	endfunction

	// base + floor(p / 2^16); result stays between corner values
	function automatic coord_t add_q16(coord_t base, prod_t p);
		sum_t s;
		s = sum_t'(base) + sum_t'(p >>> Q_FRAC);
		return coord_t'(s[CRD_W-1:0]);
	endfunction

	function automatic vec_t vadd(vec_t c, pvec_t p);
		vec_t r;
		r.x = add_q16(c.x, p.x);
		r.y = add_q16(c.y, p.y);
		r.z = add_q16(c.z, p.z);
		return r;
	endfunction

	// Partial products of a x b
	function automatic xpart_t xmul(dvec_t a, dvec_t b);
		xpart_t r;
		r.xa = xprod_t'(a.y) * xprod_t'(b.z);
		r.xb = xprod_t'(a.z) * xprod_t'(b.y);
		r.ya = xprod_t'(a.z) * xprod_t'(b.x);
		r.yb = xprod_t'(a.x) * xprod_t'(b.z);
		r.za = xprod_t'(a.x) * xprod_t'(b.y);
		r.zb = xprod_t'(a.y) * xprod_t'(b.x);
		return r;
	endfunction

	function automatic nvec_t xsum(xpart_t m);
		nvec_t r;
		r.x = norm_t'(m.xa) - norm_t'(m.xb);
		r.y = norm_t'(m.ya) - norm_t'(m.yb);
		r.z = norm_t'(m.za) - norm_t'(m.zb);
		return r;
	endfunction

endpackage

// ===== rtl/core/qpt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: cell input and vertex output.
// Depends on qpt_pkg for the payload types.

interface qpt_cell_if;
	logic           valid;
	logic           ready;
	qpt_pkg::cell_t cell_x;
	qpt_pkg::cell_t cell_y;

	modport source (output valid, output cell_x, output cell_y, input ready);
	modport sink   (input valid, input cell_x, input cell_y, output ready);
endinterface

interface qpt_vertex_if;
	logic            valid;
	logic            ready;
	qpt_pkg::coord_t pos_x;
	qpt_pkg::coord_t pos_y;
	qpt_pkg::coord_t pos_z;
	qpt_pkg::norm_t  norm_x;
	qpt_pkg::norm_t  norm_y;
	qpt_pkg::norm_t  norm_z;
	qpt_pkg::slot_t  vertex_slot;
	logic            last;

	modport source (
		output valid, output pos_x, output pos_y, output pos_z,
		output norm_x, output norm_y, output norm_z,
		output vertex_slot, output last, input ready
	);
	modport sink (
		input valid, input pos_x, input pos_y, input pos_z,
		input norm_x, input norm_y, input norm_z,
		input vertex_slot, input last, output ready
	);
endinterface

// ===== rtl/core/qpt_param.sv =====
`timescale 1ns / 1ps
// Stages s1..s4: grid check and the four patch parameters floor(k*65536/n).
// Depends on qpt_pkg (reciprocal table, types).
module qpt_param (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  qpt_pkg::cell_t cell_x,
	input  qpt_pkg::cell_t cell_y,
	input  qpt_pkg::cnt_t  subdiv,
	output logic           out_vld,
	output qpt_pkg::uv_t   uv
);
	import qpt_pkg::*;

	localparam int IDX_W = $clog2(QPT_MAX_N);
	localparam int EST_W = CNT_W + RCP_W;
	localparam int CHK_W = PARAM_W + CNT_W + 1;

	cnt_t          n_eff;
	cnt_t          n_m1;
	logic          in_grid;

	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	cnt_t          k_s1 [4];
	cnt_t          n_s1;
	rcp_t          rcp_s1;
	cnt_t          k_s2 [4];
	cnt_t          n_s2;
	param_t        qe_s2 [4];
	cnt_t          k_s3 [4];
	cnt_t          n_s3;
	param_t        qe_s3 [4];
	logic [CHK_W-2:0] t_s3 [4];
	param_t        q_s4 [4];

	// Clamp the subdivision count into 1..QPT_MAX_N
	always_comb begin
		priority if (subdiv == '0) begin
			n_eff = cnt_t'(1);
		end else if (subdiv > cnt_t'(QPT_MAX_N)) begin
			n_eff = cnt_t'(QPT_MAX_N);
		end else begin
			n_eff = subdiv;
		end
		n_m1    = n_eff - cnt_t'(1);
		in_grid = (cnt_t'(cell_x) < n_eff) && (cnt_t'(cell_y) < n_eff);
	end

	// Valid bits; a cell off the grid is dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld && in_grid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Data path: numerators, reciprocal estimate, back-multiply, correct by one
	always_ff @(posedge clk) begin
		if (en) begin
			k_s1[0] <= cnt_t'(cell_x);
			k_s1[1] <= cnt_t'(cell_x) + cnt_t'(1);
			k_s1[2] <= cnt_t'(cell_y);
			k_s1[3] <= cnt_t'(cell_y) + cnt_t'(1);
			n_s1    <= n_eff;
			rcp_s1  <= RCP_TBL[n_m1[IDX_W-1:0]];

			n_s2 <= n_s1;
			n_s3 <= n_s2;
			for (int i = 0; i < 4; i++) begin
				k_s2[i]  <= k_s1[i];
				qe_s2[i] <= param_t'((EST_W'(k_s1[i]) * EST_W'(rcp_s1)) >> RCP_SH);

				k_s3[i]  <= k_s2[i];
				qe_s3[i] <= qe_s2[i];
				t_s3[i]  <= (CHK_W-1)'(qe_s2[i]) * (CHK_W-1)'(n_s2);

				// estimate is at most one short of the exact quotient
				q_s4[i] <= qe_s3[i] + param_t'((CHK_W'(t_s3[i]) + CHK_W'(n_s3))
					<= (CHK_W'(k_s3[i]) << Q_FRAC));
			end
		end
	end

	assign out_vld = vld_s4;
	assign uv.u0   = q_s4[0];
	assign uv.u1   = q_s4[1];
	assign uv.v0   = q_s4[2];
	assign uv.v1   = q_s4[3];

endmodule

// ===== rtl/core/qpt_surface.sv =====
`timescale 1ns / 1ps
// Stages s5..s9: bilinear interpolation of the four cell corner positions.
// Depends on qpt_pkg (vector types and fixed-point helpers).
module qpt_surface (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  qpt_pkg::uv_t    uv,
	input  qpt_pkg::patch_t patch,
	output logic            out_vld,
	output qpt_pkg::quad_t  quad
);
	import qpt_pkg::*;

	logic   vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	pvec_t  pa0_s5, pa1_s5, pb0_s5, pb1_s5;
	param_t v0_s5, v1_s5;
	vec_t   a0_s6, a1_s6, b0_s6, b1_s6;
	param_t v0_s6, v1_s6;
	vec_t   a0_s7, a1_s7;
	dvec_t  d0_s7, d1_s7;
	param_t v0_s7, v1_s7;
	vec_t   a0_s8, a1_s8;
	pvec_t  q0_s8, q1_s8, q2_s8, q3_s8;
	quad_t  quad_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s5 <= in_vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s5: edge deltas scaled by u
			pa0_s5 <= vmul(patch.e01, uv.u0);
			pa1_s5 <= vmul(patch.e01, uv.u1);
			pb0_s5 <= vmul(patch.e32, uv.u0);
			pb1_s5 <= vmul(patch.e32, uv.u1);
			v0_s5  <= uv.v0;
			v1_s5  <= uv.v1;

			// s6: points on the near and far edges
			a0_s6 <= vadd(patch.c0, pa0_s5);
			a1_s6 <= vadd(patch.c0, pa1_s5);
			b0_s6 <= vadd(patch.c3, pb0_s5);
			b1_s6 <= vadd(patch.c3, pb1_s5);
			v0_s6 <= v0_s5;
			v1_s6 <= v1_s5;

			// s7: spans across v
			a0_s7 <= a0_s6;
			a1_s7 <= a1_s6;
			d0_s7 <= vsub(b0_s6, a0_s6);
			d1_s7 <= vsub(b1_s6, a1_s6);
			v0_s7 <= v0_s6;
			v1_s7 <= v1_s6;

			// s8: spans scaled by v
			a0_s8 <= a0_s7;
			a1_s8 <= a1_s7;
			q0_s8 <= vmul(d0_s7, v0_s7);
			q1_s8 <= vmul(d1_s7, v0_s7);
			q2_s8 <= vmul(d1_s7, v1_s7);
			q3_s8 <= vmul(d0_s7, v1_s7);

			// s9: p0 (u0,v0), p1 (u1,v0), p2 (u1,v1), p3 (u0,v1)
			quad_s9.p0 <= vadd(a0_s8, q0_s8);
			quad_s9.p1 <= vadd(a1_s8, q1_s8);
			quad_s9.p2 <= vadd(a1_s8, q2_s8);
			quad_s9.p3 <= vadd(a0_s8, q3_s8);
		end
	end

	assign out_vld = vld_s9;
	assign quad    = quad_s9;

endmodule

// ===== rtl/core/qpt_normal.sv =====
`timescale 1ns / 1ps
// Stages s10..s12: flat face normals of the cell's two triangles.
// Depends on qpt_pkg (vector types, cross product helpers).
module qpt_normal (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  qpt_pkg::quad_t     quad,
	output logic               out_vld,
	output qpt_pkg::cell_res_t res
);
	import qpt_pkg::*;

	logic      vld_s10, vld_s11, vld_s12;
	quad_t     quad_s10, quad_s11;
	dvec_t     ea_s10, eb_s10, fa_s10, fb_s10;
	xpart_t    m1_s11, m2_s11;
	cell_res_t res_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s10 <= in_vld;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s10: triangle edges, (p2-p1, p0-p1) and (p0-p3, p2-p3)
			quad_s10 <= quad;
			ea_s10   <= vsub(quad.p2, quad.p1);
			eb_s10   <= vsub(quad.p0, quad.p1);
			fa_s10   <= vsub(quad.p0, quad.p3);
			fb_s10   <= vsub(quad.p2, quad.p3);

			// s11: cross product terms
			quad_s11 <= quad_s10;
			m1_s11   <= xmul(ea_s10, eb_s10);
			m2_s11   <= xmul(fa_s10, fb_s10);

			// s12: combine terms
			res_s12.pos <= quad_s11;
			res_s12.n1  <= xsum(m1_s11);
			res_s12.n2  <= xsum(m2_s11);
		end
	end

	assign out_vld = vld_s12;
	assign res     = res_s12;

endmodule

// ===== rtl/core/qpt_emit.sv =====
`timescale 1ns / 1ps
// Output register: holds one finished cell and sends its six vertex beats.
// Depends on qpt_pkg and qpt_vertex_if.
module qpt_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  qpt_pkg::cell_res_t in_res,
	output logic               load,
	qpt_vertex_if.source       vtx
);
	import qpt_pkg::*;

	// Vertex order within a cell
	localparam slot_t SLOT_T1_P0 = 3'd0;
	localparam slot_t SLOT_T1_P1 = 3'd1;
	localparam slot_t SLOT_T1_P2 = 3'd2;
	localparam slot_t SLOT_T2_P0 = 3'd3;
	localparam slot_t SLOT_T2_P2 = 3'd4;
	localparam slot_t SLOT_T2_P3 = 3'd5;

	logic      busy_q;
	slot_t     slot_q;
	cell_res_t res_q;
	logic      fire;
	logic      done;
	vec_t      pos;
	nvec_t     nrm;

	assign fire = vtx.valid && vtx.ready;
	assign done = fire && (slot_q == SLOT_T2_P3);
	// take the next cell while the last beat of this one leaves
	assign load = in_vld && (!busy_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= SLOT_T1_P0;
		end else if (load) begin
			busy_q <= 1'b1;
			slot_q <= SLOT_T1_P0;
		end else if (done) begin
			busy_q <= 1'b0;
			slot_q <= SLOT_T1_P0;
		end else if (fire) begin
			slot_q <= slot_q + slot_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= in_res;
		end
	end

	// Vertex select
	always_comb begin
		unique case (slot_q)
			SLOT_T1_P0: begin pos = res_q.pos.p0; nrm = res_q.n1; end
			SLOT_T1_P1: begin pos = res_q.pos.p1; nrm = res_q.n1; end
			SLOT_T1_P2: begin pos = res_q.pos.p2; nrm = res_q.n1; end
			SLOT_T2_P0: begin pos = res_q.pos.p0; nrm = res_q.n2; end
			SLOT_T2_P2: begin pos = res_q.pos.p2; nrm = res_q.n2; end
			SLOT_T2_P3: begin pos = res_q.pos.p3; nrm = res_q.n2; end
			default:    begin pos = res_q.pos.p0; nrm = res_q.n1; end
		endcase
	end

	assign vtx.valid       = busy_q;
	assign vtx.pos_x       = pos.x;
	assign vtx.pos_y       = pos.y;
	assign vtx.pos_z       = pos.z;
	assign vtx.norm_x      = nrm.x;
	assign vtx.norm_y      = nrm.y;
	assign vtx.norm_z      = nrm.z;
	assign vtx.vertex_slot = slot_q;
	assign vtx.last        = (slot_q == SLOT_T2_P3);

endmodule

// ===== rtl/core/quad_patch_tessellator_top.sv =====
`timescale 1ns / 1ps
// Top level of the quad patch tessellator: configuration registers and pipeline.
// Depends on qpt_pkg, qpt_if, qpt_param, qpt_surface, qpt_normal, qpt_emit.
//
// Usage:
//   cfg_we/cfg_idx/cfg_wdata write the four corners (x,y,z signed Q4.12, z in
//   the low bits) and the subdivision count; write only while the block is idle.
//   Each beat on the grid_cell channel names one grid cell (cell_x, cell_y). The
//   block answers with six beats on the vertex channel, p0 p1 p2 then p0 p2 p3,
//   each with the flat normal of its triangle; last marks the sixth beat.
//   A cell outside the grid produces no beats.
// Timing:
//   Twelve pipeline stages (reciprocal divide, two interpolation multiplies,
//   cross product) and then the output register. A new cell may enter
//   every cycle unless the pipeline is stalled; the output register sends
//   one vertex per cycle while the receiver is ready, six per cell.
// Reset and stalls:
//   Reset clears corners to zero, subdivisions to one and empties the pipeline.
//   When the vertex receiver stalls, the held beat stays put and the whole
//   pipeline freezes once its last stage is full; nothing is lost or repeated.
module quad_patch_tessellator_top (
	input  logic                clk,
	input  logic                arst_n,
	qpt_cell_if.sink            grid_cell,
	qpt_vertex_if.source        vertex,
	input  logic                cfg_we,
	input  qpt_pkg::reg_idx_t   cfg_idx,
	input  qpt_pkg::cfg_data_t  cfg_wdata
);
	import qpt_pkg::*;

	vec_t      corner_q [4];
	cnt_t      subdiv_q;
	patch_t    patch_q;

	logic      en;
	logic      load;
	logic      uv_vld;
	uv_t       uv;
	logic      quad_vld;
	quad_t     quad;
	logic      res_vld;
	cell_res_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q[0] <= '0;
			corner_q[1] <= '0;
			corner_q[2] <= '0;
			corner_q[3] <= '0;
			subdiv_q    <= cnt_t'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CORNER_ZERO:  corner_q[0] <= vec_t'(cfg_wdata);
				REG_CORNER_ONE:   corner_q[1] <= vec_t'(cfg_wdata);
				REG_CORNER_TWO:   corner_q[2] <= vec_t'(cfg_wdata);
				REG_CORNER_THREE: corner_q[3] <= vec_t'(cfg_wdata);
				REG_SUBDIVISIONS: subdiv_q    <= cfg_wdata[CNT_W-1:0];
				default:          ;
			endcase
		end
	end

	// Edge vectors of the patch, refreshed every cycle
	always_ff @(posedge clk) begin
		patch_q.c0  <= corner_q[0];
		patch_q.c3  <= corner_q[3];
		patch_q.e01 <= vsub(corner_q[1], corner_q[0]);
		patch_q.e32 <= vsub(corner_q[2], corner_q[3]);
	end

	// Pipeline advances unless a full last stage cannot hand over
	assign en              = !res_vld || load;
	assign grid_cell.ready = en;

	qpt_param u_param (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (grid_cell.valid),
		.cell_x  (grid_cell.cell_x),
		.cell_y  (grid_cell.cell_y),
		.subdiv  (subdiv_q),
		.out_vld (uv_vld),
		.uv      (uv)
	);

	qpt_surface u_surface (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (uv_vld),
		.uv      (uv),
		.patch   (patch_q),
		.out_vld (quad_vld),
		.quad    (quad)
	);

	qpt_normal u_normal (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (quad_vld),
		.quad    (quad),
		.out_vld (res_vld),
		.res     (res)
	);

	qpt_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (res_vld),
		.in_res (res),
		.load   (load),
		.vtx    (vertex)
	);

endmodule

// ===== sim/qpt_vertex_check.sv =====
`timescale 1ns / 1ps
// Scoreboard for the quad patch tessellator: shadows the register file, predicts the
// six vertex beats of every accepted cell on the grid and compares them in order of arrival.
// Depends on qpt_pkg and the channel interfaces in qpt_if.
module qpt_vertex_check (
	input  logic               clk,
	input  logic               arst_n,
	qpt_cell_if                cell_mon,
	qpt_vertex_if              vtx_mon,
	input  logic               cfg_we,
	input  qpt_pkg::reg_idx_t  cfg_idx,
	input  qpt_pkg::cfg_data_t cfg_wdata,
	output int                 mismatches,
	output int                 beats_owed
);
	import qpt_pkg::*;

	localparam int VERTS_PER_CELL = 6;

	typedef logic signed [63:0] wide_t;
	typedef struct packed {
		wide_t x;
		wide_t y;
		wide_t z;
	} wvec_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		norm_t  norm_x;
		norm_t  norm_y;
		norm_t  norm_z;
		slot_t  vertex_slot;
		logic   last;
	} vertex_beat_t;

	cfg_data_t    corner_reg [4];
	cnt_t         subdiv_reg;
	vertex_beat_t vtx_due [$];

	function automatic wvec_t unpack_corner(cfg_data_t r);
		vec_t  c;
		wvec_t w;
		c = vec_t'(r);
		w.x = wide_t'(c.x);
		w.y = wide_t'(c.y);
		w.z = wide_t'(c.z);
		return w;
	endfunction

	function automatic wvec_t wsub(wvec_t a, wvec_t b);
		wvec_t r;
		r.x = a.x - b.x;
		r.y = a.y - b.y;
		r.z = a.z - b.z;
		return r;
	endfunction

	function automatic wvec_t wcross(wvec_t a, wvec_t b);
		wvec_t r;
		r.x = a.y * b.z - a.z * b.y;
		r.y = a.z * b.x - a.x * b.z;
		r.z = a.x * b.y - a.y * b.x;
		return r;
	endfunction

	// Bilinear blend of one component; the shifts floor towards minus infinity
	function automatic wide_t blend(wide_t b0, wide_t b3, wide_t d01, wide_t d32,
			wide_t u, wide_t v);
		wide_t a, b;
		a = b0 + ((d01 * u) >>> Q_FRAC);
		b = b3 + ((d32 * u) >>> Q_FRAC);
		return a + (((b - a) * v) >>> Q_FRAC);
	endfunction

	function automatic wvec_t surface_point(wvec_t c0, wvec_t c3, wvec_t e01, wvec_t e32,
			wide_t u, wide_t v);
		wvec_t r;
		r.x = blend(c0.x, c3.x, e01.x, e32.x, u, v);
		r.y = blend(c0.y, c3.y, e01.y, e32.y, u, v);
		r.z = blend(c0.z, c3.z, e01.z, e32.z, u, v);
		return r;
	endfunction

	// Queue the six vertices of one cell; cells off the grid give nothing
	task automatic predict_cell(cell_t cx, cell_t cy);
		wide_t        n, ua, ub, va, vb;
		wvec_t        c0, c3, e01, e32, nrm1, nrm2, nrm;
		wvec_t        p [4];
		int           corner_of [VERTS_PER_CELL] = '{0, 1, 2, 0, 2, 3};
		vertex_beat_t b;
		n = (subdiv_reg == 0) ? 1 : (subdiv_reg > QPT_MAX_N) ? QPT_MAX_N : subdiv_reg;
		if (cx >= n || cy >= n)
			return;
		ua = (wide_t'(cx) <<< Q_FRAC) / n;
		ub = ((wide_t'(cx) + 1) <<< Q_FRAC) / n;
		va = (wide_t'(cy) <<< Q_FRAC) / n;
		vb = ((wide_t'(cy) + 1) <<< Q_FRAC) / n;
		c0  = unpack_corner(corner_reg[0]);
		c3  = unpack_corner(corner_reg[3]);
		e01 = wsub(unpack_corner(corner_reg[1]), c0);
		e32 = wsub(unpack_corner(corner_reg[2]), c3);
		p[0] = surface_point(c0, c3, e01, e32, ua, va);
		p[1] = surface_point(c0, c3, e01, e32, ub, va);
		p[2] = surface_point(c0, c3, e01, e32, ub, vb);
		p[3] = surface_point(c0, c3, e01, e32, ua, vb);
		nrm1 = wcross(wsub(p[2], p[1]), wsub(p[0], p[1]));
		nrm2 = wcross(wsub(p[0], p[3]), wsub(p[2], p[3]));
		for (int s = 0; s < VERTS_PER_CELL; s++) begin
			nrm = (s < 3) ? nrm1 : nrm2;
			b.pos_x       = coord_t'(p[corner_of[s]].x);
			b.pos_y       = coord_t'(p[corner_of[s]].y);
			b.pos_z       = coord_t'(p[corner_of[s]].z);
			b.norm_x      = norm_t'(nrm.x);
			b.norm_y      = norm_t'(nrm.y);
			b.norm_z      = norm_t'(nrm.z);
			b.vertex_slot = slot_t'(s);
			b.last        = (s == VERTS_PER_CELL - 1);
			vtx_due.push_back(b);
		end
	endtask

	task automatic check_field(string field, wide_t want, wide_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Register shadow, then output beat before input beat so a stray vertex is caught
	always @(posedge clk or negedge arst_n) begin
		vertex_beat_t want;
		if (!arst_n) begin
			corner_reg = '{default: '0};
			subdiv_reg = cnt_t'(1);
			vtx_due.delete();
			beats_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_CORNER_ZERO:  corner_reg[0] = cfg_wdata;
					REG_CORNER_ONE:   corner_reg[1] = cfg_wdata;
					REG_CORNER_TWO:   corner_reg[2] = cfg_wdata;
					REG_CORNER_THREE: corner_reg[3] = cfg_wdata;
					REG_SUBDIVISIONS: subdiv_reg = cnt_t'(cfg_wdata);
					default: ;
				endcase
			end
			if (vtx_mon.valid && vtx_mon.ready) begin
				if (vtx_due.size() == 0) begin
					$error("vertex beat with no cell outstanding");
					mismatches++;
				end else begin
					want = vtx_due.pop_front();
					check_field("pos_x", want.pos_x, vtx_mon.pos_x);
					check_field("pos_y", want.pos_y, vtx_mon.pos_y);
					check_field("pos_z", want.pos_z, vtx_mon.pos_z);
					check_field("norm_x", want.norm_x, vtx_mon.norm_x);
					check_field("norm_y", want.norm_y, vtx_mon.norm_y);
					check_field("norm_z", want.norm_z, vtx_mon.norm_z);
					check_field("vertex_slot", want.vertex_slot, vtx_mon.vertex_slot);
					check_field("last", want.last, vtx_mon.last);
				end
			end
			if (cell_mon.valid && cell_mon.ready)
				predict_cell(cell_mon.cell_x, cell_mon.cell_y);
			beats_owed <= vtx_due.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the quad patch tessellator: clock, reset, register writes,
// cell stimulus with random idling and vertex back-pressure, verdict.
// Depends on qpt_pkg, qpt_if, the block itself and qpt_vertex_check.
module tb;
	import qpt_pkg::*;

	localparam int       CLK_PERIOD      = 10;
	localparam int       RESET_CYCLES    = 5;
	localparam int       DRAIN_CYCLES    = 24;   // twelve pipeline stages plus margin
	localparam int       LONG_HOLD       = 400;
	localparam int       STALL_LIMIT     = 5000;
	localparam int       CELLS_PER_PATCH = 28;
	localparam reg_idx_t REG_IDX_LAST    = '1;
	localparam reg_idx_t PATCH_REGS [5]  = '{REG_CORNER_ZERO, REG_CORNER_ONE,
		REG_CORNER_TWO, REG_CORNER_THREE, REG_SUBDIVISIONS};
	localparam coord_t   COORD_MIN       = coord_t'(16'h8000);
	localparam coord_t   COORD_MAX       = coord_t'(16'h7fff);

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_we;
	reg_idx_t  cfg_idx;
	cfg_data_t cfg_wdata;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        hold_requests;
	int        idle_cycles;
	int        mismatches;
	int        beats_owed;

	qpt_cell_if   cell_ch ();
	qpt_vertex_if vertex_ch ();

	quad_patch_tessellator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_cell (cell_ch),
		.vertex    (vertex_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	qpt_vertex_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_mon   (cell_ch),
		.vtx_mon    (vertex_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.beats_owed (beats_owed)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int grid_size(cnt_t n);
		if (n == 0)
			return 1;
		if (n > QPT_MAX_N)
			return QPT_MAX_N;
		return n;
	endfunction

	// Mostly random components, with the extremes and zero mixed in
	function automatic cfg_data_t pick_corner();
		coord_t comp [3];
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(7))
				0: comp[k] = COORD_MIN;
				1: comp[k] = COORD_MAX;
				2: comp[k] = '0;
				default: comp[k] = coord_t'($urandom);
			endcase
		end
		return {comp[0], comp[1], comp[2]};
	endfunction

	// Subdivision word: zero and over-range counts included, junk above bit 6 at times
	function automatic cfg_data_t pick_subdiv();
		cnt_t      n;
		cfg_data_t w;
		case ($urandom_range(9))
			0: n = '0;
			1: n = cnt_t'($urandom_range(QPT_MAX_N + 1, (1 << CNT_W) - 1));
			2: n = cnt_t'(QPT_MAX_N);
			3: n = cnt_t'(1);
			default: n = cnt_t'($urandom_range(1, QPT_MAX_N));
		endcase
		w = cfg_data_t'({$urandom, $urandom});
		w[CNT_W-1:0] = n;
		return $urandom_range(1) ? w : cfg_data_t'(n);
	endfunction

	task automatic send_cell(input cell_t cx, input cell_t cy);
		while ($urandom_range(99) < send_idle_pct) begin
			cell_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cell_ch.valid  <= 1'b1;
		cell_ch.cell_x <= cx;
		cell_ch.cell_y <= cy;
		@(posedge clk);
		while (!cell_ch.ready)
			@(posedge clk);
	endtask

	// Stop offering cells, wait for every vertex owed, then let dropped cells clear
	task automatic drain();
		cell_ch.valid <= 1'b0;
		@(posedge clk);
		while (beats_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_patch(input cfg_data_t c0, input cfg_data_t c1, input cfg_data_t c2,
			input cfg_data_t c3, input cfg_data_t sub_word);
		cfg_data_t vals [5];
		vals = '{c0, c1, c2, c3, sub_word};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= PATCH_REGS[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		// unmapped index: must leave the patch untouched
		cfg_idx   <= reg_idx_t'($urandom_range(REG_SUBDIVISIONS + 1, REG_IDX_LAST));
		cfg_wdata <= cfg_data_t'({$urandom, $urandom});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Vertex receiver: random stalls plus the occasional long hold-off
	initial begin
		int hold_left;
		int holds_done;
		hold_left  = 0;
		holds_done = 0;
		vertex_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				vertex_ch.ready <= 1'b0;
			end else
				vertex_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((cell_ch.valid && cell_ch.ready) || (vertex_ch.valid && vertex_ch.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		cfg_data_t corner_a, corner_b, corner_c, corner_d, sub_word;
		int        n_cells;
		int        cells_on_grid;
		cell_t     cx, cy;
		cell_ch.valid  = 1'b0;
		cell_ch.cell_x = '0;
		cell_ch.cell_y = '0;
		cfg_we         = 1'b0;
		cfg_idx        = REG_CORNER_ZERO;
		cfg_wdata      = '0;
		arst_n         = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 28;
		recv_idle_pct = 63;

		// Reset patch: 1x1 grid of zeros; anything off it is dropped
		send_cell(0, 0);
		send_cell(1, 0);
		send_cell(63, 63);
		drain();

		// Corners at the coordinate extremes, finest grid, all four grid corners
		corner_a = {COORD_MIN, COORD_MIN, COORD_MAX};
		corner_b = {COORD_MAX, COORD_MIN, COORD_MIN};
		corner_c = {COORD_MAX, COORD_MAX, COORD_MAX};
		corner_d = {COORD_MIN, COORD_MAX, COORD_MIN};
		load_patch(corner_a, corner_b, corner_c, corner_d, cfg_data_t'(QPT_MAX_N));
		send_cell(0, 0);
		send_cell(63, 63);
		send_cell(63, 0);
		send_cell(0, 63);
		send_cell(31, 32);
		drain();

		// Zero count behaves as a single cell
		load_patch(corner_d, corner_c, corner_b, corner_a, '0);
		send_cell(0, 0);
		send_cell(0, 1);
		drain();

		// Counts above the limit clamp to the largest grid
		load_patch(corner_b, corner_a, corner_d, corner_c,
			cfg_data_t'({$urandom, $urandom}) | cfg_data_t'((1 << CNT_W) - 1));
		send_cell(63, 63);
		send_cell(0, 0);
		drain();
		load_patch(corner_c, corner_d, corner_a, corner_b, cfg_data_t'(QPT_MAX_N + 1));
		send_cell(63, 0);
		drain();

		// Count that does not divide 2^16; one column just off the grid
		load_patch(pick_corner(), pick_corner(), pick_corner(), pick_corner(), 3);
		send_cell(2, 2);
		send_cell(3, 0);
		send_cell(0, 2);
		drain();

		// Collapsed patch: every normal is zero; then a single-cell patch
		load_patch(corner_a, corner_a, corner_a, corner_a, 7);
		send_cell(6, 6);
		drain();
		load_patch(corner_c, corner_d, corner_a, corner_b, 1);
		send_cell(0, 0);

		// Random patches under three idling regimes
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 28 : (mode == 1) ? 63 : 0;
			recv_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 28 : 0;
			for (int patch = 0; patch < 4; patch++) begin
				drain();
				sub_word = pick_subdiv();
				load_patch(pick_corner(), pick_corner(), pick_corner(), pick_corner(),
					sub_word);
				n_cells = grid_size(cnt_t'(sub_word));
				// back-pressure burst: receiver goes quiet while cells keep coming
				if (mode == 2 && patch == 0)
					hold_requests++;
				cells_on_grid = 0;
				while (cells_on_grid < CELLS_PER_PATCH) begin
					if ($urandom_range(99) < 85) begin
						cx = cell_t'($urandom_range(n_cells - 1));
						cy = cell_t'($urandom_range(n_cells - 1));
					end else begin
						cx = cell_t'($urandom);
						cy = cell_t'($urandom);
					end
					if (cx < n_cells && cy < n_cells)
						cells_on_grid++;
					send_cell(cx, cy);
				end
			end
		end

		drain();
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/qpt_pkg.sv
rtl/core/qpt_if.sv
rtl/core/qpt_param.sv
rtl/core/qpt_surface.sv
rtl/core/qpt_normal.sv
rtl/core/qpt_emit.sv
rtl/core/quad_patch_tessellator_top.sv
sim/qpt_vertex_check.sv
sim/tb.sv
